/* hw/rtl/bcfd_pkg.sv */
package bcfd_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned ID_W   = 11;
    localparam int unsigned LEN_W  = 4;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned HALF_W = 16;
    localparam int unsigned IDX_W  = 8;

    // Packed widths of the stream payloads, rounded up to whole bytes.
    localparam int unsigned S_TDATA_W = 112;
    localparam int unsigned M_TDATA_W = 152;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_STATUS  = 3'd1,
        EV_LIMITS  = 3'd2,
        EV_ALARM   = 3'd3,
        EV_TIMEOUT = 3'd4
    } event_kind_t;

    localparam logic [IDX_W-1:0] CFG_IDX_TIMEOUT = 8'd0;
    localparam logic [IDX_W-1:0] CFG_IDX_STATUS  = 8'd1;
    localparam logic [IDX_W-1:0] CFG_IDX_LIMITS  = 8'd2;
    localparam logic [IDX_W-1:0] CFG_IDX_ALARM   = 8'd3;

    localparam logic [HALF_W-1:0] TIMEOUT_RST   = 16'd1000;
    localparam logic [ID_W-1:0]   STATUS_ID_RST = 11'h351;
    localparam logic [ID_W-1:0]   LIMITS_ID_RST = 11'h355;
    localparam logic [ID_W-1:0]   ALARM_ID_RST  = 11'h359;
    localparam logic [LEN_W-1:0]  FULL_LEN      = 4'd8;

    typedef struct packed {
        logic [HALF_W-1:0] timeout_ms;
        logic [ID_W-1:0]   status_id;
        logic [ID_W-1:0]   limits_id;
        logic [ID_W-1:0]   alarm_id;
    } cfg_t;

    typedef struct packed {
        logic              req_type;
        logic [TIME_W-1:0] now_ms;
        logic [ID_W-1:0]   frame_id;
        logic [LEN_W-1:0]  frame_len;
        logic [WORD_W-1:0] data_low;
        logic [WORD_W-1:0] data_high;
    } item_t;

    typedef struct packed {
        event_kind_t              event_kind;
        logic                     link_online;
        logic [HALF_W-1:0]        charge_state;
        logic [HALF_W-1:0]        health_state;
        logic signed [HALF_W-1:0] pack_voltage;
        logic signed [HALF_W-1:0] pack_current;
        logic signed [HALF_W-1:0] max_temp;
        logic [HALF_W-1:0]        charge_limit;
        logic [HALF_W-1:0]        discharge_limit;
        logic [HALF_W-1:0]        alarm_word;
        logic [HALF_W-1:0]        fault_word;
        logic                     alarm_changed;
    } result_t;

endpackage

/* hw/rtl/bms_can_frame_decoder.sv */
// Battery-management CAN frame decoder. Each input transaction is either a
// received CAN frame (s_tuser = 0) or a time tick (s_tuser = 1), and each one
// yields exactly one result transaction carrying the event kind on m_tuser and
// the full battery status on m_tdata. An item is registered on entry, then
// decoded and applied to the status registers as its result is written into
// the output register; while m_tready is high a new item is taken every
// cycle. The output register and the input register together let one item
// enter while a finished result still waits on m_tready. The configuration
// channel is always ready and must only be written while no transaction is in
// flight; indexes beyond the alarm identifier are ignored.
module bms_can_frame_decoder
    import bcfd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [31:0] now_ms, [42:32] frame_id, [46:43] frame_len, [78:47] data_low,
    // [110:79] data_high, [111] zero.
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] req_type.
    input  logic [0:0]           s_tuser,
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] link_online, [16:1] charge_state, [32:17] health_state,
    // [48:33] pack_voltage, [64:49] pack_current, [80:65] max_temp,
    // [96:81] charge_limit, [112:97] discharge_limit, [128:113] alarm_word,
    // [144:129] fault_word, [145] alarm_changed, [151:146] zero.
    output logic [M_TDATA_W-1:0] m_tdata,
    // [2:0] event_kind.
    output logic [2:0]           m_tuser,
    // Configuration writes.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [HALF_W-1:0]    cfg_data
);

    cfg_t    cfg_reg;
    logic    item_valid;
    item_t   item;
    logic    advance;
    result_t result;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ms <= TIMEOUT_RST;
            cfg_reg.status_id  <= STATUS_ID_RST;
            cfg_reg.limits_id  <= LIMITS_ID_RST;
            cfg_reg.alarm_id   <= ALARM_ID_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_IDX_TIMEOUT: cfg_reg.timeout_ms <= cfg_data;
                CFG_IDX_STATUS:  cfg_reg.status_id  <= cfg_data[ID_W-1:0];
                CFG_IDX_LIMITS:  cfg_reg.limits_id  <= cfg_data[ID_W-1:0];
                CFG_IDX_ALARM:   cfg_reg.alarm_id   <= cfg_data[ID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // An item moves into the core whenever the output register is free or
    // is being emptied in this cycle.
    assign advance = item_valid && (!out_valid_reg || m_tready);

    bcfd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bcfd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .item    (item),
        .advance (advance),
        .result  (result)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_kind;
    assign m_tdata  = {6'b0,
                       out_reg.alarm_changed,
                       out_reg.fault_word,
                       out_reg.alarm_word,
                       out_reg.discharge_limit,
                       out_reg.charge_limit,
                       out_reg.max_temp,
                       out_reg.pack_current,
                       out_reg.pack_voltage,
                       out_reg.health_state,
                       out_reg.charge_state,
                       out_reg.link_online};

endmodule

/* hw/rtl/bcfd_in_reg.sv */
module bcfd_in_reg
    import bcfd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,
    input  logic                 advance,
    output logic                 item_valid,
    output item_t                item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // The slot frees up in the same cycle its item moves into the core.
    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg.req_type  <= s_tuser[0];
            item_reg.now_ms    <= s_tdata[31:0];
            item_reg.frame_id  <= s_tdata[42:32];
            item_reg.frame_len <= s_tdata[46:43];
            item_reg.data_low  <= s_tdata[78:47];
            item_reg.data_high <= s_tdata[110:79];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hw/rtl/bcfd_core.sv */
module bcfd_core
    import bcfd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  item_t   item,
    input  logic    advance,
    output result_t result
);

    logic              online_reg, online_next;
    logic              latched_reg, latched_next;
    logic [TIME_W-1:0] last_rx_reg, last_rx_next;
    logic [HALF_W-1:0] soc_reg, soc_next;
    logic [HALF_W-1:0] soh_reg, soh_next;
    logic [HALF_W-1:0] voltage_reg, voltage_next;
    logic [HALF_W-1:0] current_reg, current_next;
    logic [HALF_W-1:0] temp_reg, temp_next;
    logic [HALF_W-1:0] chg_limit_reg, chg_limit_next;
    logic [HALF_W-1:0] dis_limit_reg, dis_limit_next;
    logic [HALF_W-1:0] alarm_reg, alarm_next;
    logic [HALF_W-1:0] fault_reg, fault_next;

    logic              frame_ok;
    logic [TIME_W-1:0] elapsed;
    logic              expired;
    event_kind_t       kind;
    logic              changed;

    assign frame_ok = !item.req_type && (item.frame_len == FULL_LEN);
    assign elapsed  = item.now_ms - last_rx_reg;
    assign expired  = elapsed > {{(TIME_W-HALF_W){1'b0}}, cfg.timeout_ms};

    always_comb begin
        online_next    = online_reg;
        latched_next   = latched_reg;
        last_rx_next   = last_rx_reg;
        soc_next       = soc_reg;
        soh_next       = soh_reg;
        voltage_next   = voltage_reg;
        current_next   = current_reg;
        temp_next      = temp_reg;
        chg_limit_next = chg_limit_reg;
        dis_limit_next = dis_limit_reg;
        alarm_next     = alarm_reg;
        fault_next     = fault_reg;
        kind           = EV_NONE;
        changed        = 1'b0;

        if (frame_ok) begin
            // Coinciding identifiers resolve in favor of status, then limits.
            if (item.frame_id == cfg.status_id) begin
                kind         = EV_STATUS;
                soc_next     = item.data_low[15:0];
                soh_next     = item.data_low[31:16];
                voltage_next = item.data_high[15:0];
                current_next = item.data_high[31:16];
            end else if (item.frame_id == cfg.limits_id) begin
                kind           = EV_LIMITS;
                temp_next      = item.data_low[15:0];
                chg_limit_next = item.data_low[31:16];
                dis_limit_next = item.data_high[15:0];
            end else if (item.frame_id == cfg.alarm_id) begin
                kind       = EV_ALARM;
                alarm_next = item.data_low[15:0];
                fault_next = item.data_low[31:16];
                changed    = (alarm_reg != item.data_low[15:0]) ||
                             (fault_reg != item.data_low[31:16]);
            end
            if (kind != EV_NONE) begin
                online_next  = 1'b1;
                latched_next = 1'b0;
                last_rx_next = item.now_ms;
            end
        end else if (item.req_type) begin
            if (online_reg && !latched_reg && expired) begin
                kind         = EV_TIMEOUT;
                online_next  = 1'b0;
                latched_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            online_reg    <= 1'b0;
            latched_reg   <= 1'b0;
            last_rx_reg   <= '0;
            soc_reg       <= '0;
            soh_reg       <= '0;
            voltage_reg   <= '0;
            current_reg   <= '0;
            temp_reg      <= '0;
            chg_limit_reg <= '0;
            dis_limit_reg <= '0;
            alarm_reg     <= '0;
            fault_reg     <= '0;
        end else if (advance) begin
            online_reg    <= online_next;
            latched_reg   <= latched_next;
            last_rx_reg   <= last_rx_next;
            soc_reg       <= soc_next;
            soh_reg       <= soh_next;
            voltage_reg   <= voltage_next;
            current_reg   <= current_next;
            temp_reg      <= temp_next;
            chg_limit_reg <= chg_limit_next;
            dis_limit_reg <= dis_limit_next;
            alarm_reg     <= alarm_next;
            fault_reg     <= fault_next;
        end
    end

    // The result reports the state as it stands after this transaction.
    always_comb begin
        result.event_kind      = kind;
        result.link_online     = online_next;
        result.charge_state    = soc_next;
        result.health_state    = soh_next;
        result.pack_voltage    = voltage_next;
        result.pack_current    = current_next;
        result.max_temp        = temp_next;
        result.charge_limit    = chg_limit_next;
        result.discharge_limit = dis_limit_next;
        result.alarm_word      = alarm_next;
        result.fault_word      = fault_next;
        result.alarm_changed   = changed;
    end

endmodule

/* hw/rtl/bcfd_checker.sv */
module bcfd_checker
    import bcfd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [2:0]           m_tuser
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed or dropped");

    // An accepted frame always leaves the link online.
    a_frame_online: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == EV_STATUS || m_tuser == EV_LIMITS ||
                     m_tuser == EV_ALARM) |-> m_tdata[0])
        else $error("frame event with link offline");

    a_timeout_offline: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_TIMEOUT |-> !m_tdata[0])
        else $error("timeout event with link online");

    a_changed_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[145] |-> m_tuser == EV_ALARM)
        else $error("alarm change flagged outside an alarm frame");

endmodule

bind bms_can_frame_decoder bcfd_checker u_bcfd_checker (.*);
